@@ hw/rtl/led_bar_fill_ramp_macros.svh @@
// assertion macros for the led bar fill ramp block
// used by the top level only, no other dependencies
`ifndef LED_BAR_FILL_RAMP_MACROS_SVH
`define LED_BAR_FILL_RAMP_MACROS_SVH

// antecedent implies consequent in the same cycle
`define LBFR_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define LBFR_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/lbfr_pkg.sv @@
// shared types, constants and helper functions for the led bar fill ramp
// no dependencies
package lbfr_pkg;

  localparam int MAX_LEDS_DEF = 64;
  localparam int POS_W        = 13;
  localparam int MBREM_W      = 8 + POS_W;  // max_bright times remainder
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 13;

  // command codes
  localparam logic [2:0] CMD_TICK    = 3'd0;
  localparam logic [2:0] CMD_ENABLE  = 3'd1;
  localparam logic [2:0] CMD_TOGGLE  = 3'd2;
  localparam logic [2:0] CMD_SET_COL = 3'd3;
  localparam logic [2:0] CMD_SET_POS = 3'd4;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LED_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POS_COUNT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STEP      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_BR    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_BR    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_REVERSE   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_PERIODIC  = 3'd7;

  // reset values
  localparam logic [6:0]       RST_LED_COUNT = 7'd24;
  localparam logic [POS_W-1:0] RST_POS_COUNT = 13'd24;
  localparam logic [7:0]       RST_STEP      = 8'd255;
  localparam logic [7:0]       RST_MAX_BR    = 8'd255;
  localparam logic [7:0]       RST_MIN_BR    = 8'd0;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  localparam rgb_t RST_TARGET = '{red: 8'd0, green: 8'd0, blue: 8'd255};

  // one colour channel moved toward its target by at most step
  function automatic logic [7:0] move_toward(input logic [7:0] cur, input logic [7:0] tgt,
                                             input logic [7:0] step);
    logic [7:0] res;
    res = tgt;
    if (cur < tgt) begin
      if (tgt - cur > step) res = cur + step;
    end else if (cur > tgt) begin
      if (cur - tgt > step) res = cur - step;
    end
    return res;
  endfunction

  // exact floor(x / 255) for any 16-bit x up to 65279, which holds every 8 by 8 bit product
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] s;
    s = {1'b0, x} + 17'(x[15:8]) + 17'd1;
    return s[15:8];
  endfunction

endpackage

@@ hw/rtl/led_bar_fill_ramp.sv @@
// led bar fill ramp: command decode, fill divider, brightness memory scan and frame output
// depends on lbfr_pkg and led_bar_fill_ramp_macros.svh
//
//  channel | signals                                   | handshake
//  --------+-------------------------------------------+-----------------------------
//  cfg     | cfg_we_i cfg_idx_i cfg_data_i             | write on cfg_we_i, no wait
//  in      | cmd_i enable_on_i new_*_i new_position_i  | in_valid_i / in_ready_o
//  out     | pixel_index_o out_*_o frame_last_o        | out_valid_o / out_ready_i
//
// commands other than tick finish as they are taken; a tick with n leds runs the
// shared restoring divider (DW = 21 for 64 leds) twice, reducing strip_offset
// modulo n between the divisions, then scans n entries of the brightness memory,
// passes the write-back states ST_WB1 and ST_WB2 and, when a frame goes out, takes
// each pixel through memory read, multiply and output transfer, plus output stalls.
// after reset a clearing pass zeroes all MAX_LEDS memory entries; no item is taken then.
module led_bar_fill_ramp
  import lbfr_pkg::*;
#(
  parameter int MAX_LEDS = MAX_LEDS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [2:0]            cmd_i,
  input  logic                  enable_on_i,
  input  logic [7:0]            new_red_i,
  input  logic [7:0]            new_green_i,
  input  logic [7:0]            new_blue_i,
  input  logic signed [13:0]    new_position_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [5:0]            pixel_index_o,
  output logic [7:0]            out_red_o,
  output logic [7:0]            out_green_o,
  output logic [7:0]            out_blue_o,
  output logic                  frame_last_o
);

  localparam int NW   = $clog2(MAX_LEDS + 1);
  localparam int AW   = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
  localparam int PW   = NW + POS_W;
  localparam int DW   = (PW > MBREM_W) ? PW : MBREM_W;
  localparam int CNTW = $clog2(DW + 1);
  localparam int OW   = (NW > 7) ? NW : 7;

  typedef enum logic [9:0] {
    ST_CLEAR = 10'b0000000001,
    ST_IDLE  = 10'b0000000010,
    ST_DIV1  = 10'b0000000100,
    ST_DIV2  = 10'b0000001000,
    ST_SCAN  = 10'b0000010000,
    ST_WB1   = 10'b0000100000,
    ST_WB2   = 10'b0001000000,
    ST_EMRD  = 10'b0010000000,
    ST_EMMUL = 10'b0100000000,
    ST_EMOUT = 10'b1000000000
  } state_e;

  state_e state_q, state_d;

  // configuration registers
  logic [6:0]       led_count_q, offset_q;
  logic [POS_W-1:0] pos_count_q;
  logic [7:0]       step_q, max_b_q, min_b_q;
  logic             rev_q, periodic_q;

  // block state
  logic             bar_on_q;
  rgb_t             tgt_col_q, cur_col_q;
  logic [POS_W-1:0] fill_q;

  // tick working registers
  logic [NW-1:0]    n_q;
  logic [POS_W-1:0] p_q;
  logic [6:0]       offr_q;
  logic [DW-1:0]    dq_q, k_q;
  logic [POS_W-1:0] rr_q;
  logic [CNTW-1:0]  dcnt_q;
  logic [7:0]       bnd_q;
  logic             col_chg_q;

  // scan pipeline
  logic [NW-1:0]    cnt_q, p_idx_q;
  logic             p_vld_q, prev_mis_q;
  logic             rise_found_q, rise_do_q, fall_found_q, fall_pend_q, fall_blk_q;
  logic [AW-1:0]    rise_idx_q, fall_idx_q;
  logic [7:0]       rise_val_q, fall_val_q;

  // emit
  logic [NW-1:0]    o_q, i_q, clr_q;
  logic [15:0]      pr_r_q, pr_g_q, pr_b_q;

  // brightness memory
  logic [7:0]       lb_mem [MAX_LEDS];
  logic [7:0]       rd_q;
  logic             mem_we;
  logic [AW-1:0]    mem_waddr, mem_raddr;
  logic [7:0]       mem_wdata;

  logic in_xfer, out_xfer;
  assign in_xfer  = in_valid_i && in_ready_o;
  assign out_xfer = out_valid_o && out_ready_i;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = (state_q == ST_EMOUT);

  // divider step
  logic [POS_W:0] dv_t, dv_sub;
  logic           dv_ge;
  assign dv_t   = {rr_q, dq_q[DW-1]};
  assign dv_ge  = dv_t >= {1'b0, p_q};
  assign dv_sub = dv_t - {1'b0, p_q};

  // with no leds there is nothing to rotate
  logic off_big;
  assign off_big = (n_q != '0) && (OW'(offr_q) >= OW'(n_q));

  // scan element: target brightness and ramp candidates
  logic [7:0] s_d, s_t, s_rval, s_fval, s_post;
  logic       s_rise, s_fall, s_first, s_allow;
  always_comb begin
    s_d = rd_q;
    if (!bar_on_q) s_t = min_b_q;
    else if (DW'(p_idx_q) < k_q) s_t = max_b_q;
    else if (DW'(p_idx_q) == k_q && p_idx_q != '0) s_t = bnd_q;
    else s_t = min_b_q;
    s_rise  = s_t > s_d;
    s_fall  = s_t < s_d;
    s_first = p_vld_q && s_rise && !rise_found_q;
    s_allow = !((p_idx_q != '0) && prev_mis_q);
    s_rval  = (s_t - s_d < step_q) ? s_t : s_d + step_q;
    s_fval  = (s_d - s_t < step_q) ? s_t : s_d - step_q;
    s_post  = (s_first && s_allow) ? s_rval : s_d;
  end

  logic frame_go;
  assign frame_go = col_chg_q || rise_found_q || fall_found_q || periodic_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: if (clr_q == NW'(MAX_LEDS - 1)) state_d = ST_IDLE;
      ST_IDLE:  if (in_xfer && cmd_i == CMD_TICK) state_d = ST_DIV1;
      ST_DIV1:  if (dcnt_q == '0 && !off_big) state_d = ST_DIV2;
      ST_DIV2:  if (dcnt_q == '0) state_d = (n_q == '0) ? ST_IDLE : ST_SCAN;
      ST_SCAN:  if (cnt_q == n_q && !p_vld_q) state_d = ST_WB1;
      ST_WB1:   state_d = ST_WB2;
      ST_WB2:   state_d = frame_go ? ST_EMRD : ST_IDLE;
      ST_EMRD:  state_d = ST_EMMUL;
      ST_EMMUL: state_d = ST_EMOUT;
      ST_EMOUT: if (out_ready_i) state_d = (o_q == n_q - NW'(1)) ? ST_IDLE : ST_EMRD;
      default:  state_d = ST_IDLE;
    endcase
  end

  // memory port control
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = clr_q[AW-1:0];
    mem_wdata = '0;
    mem_raddr = (state_q == ST_SCAN) ? cnt_q[AW-1:0] : i_q[AW-1:0];
    priority case (1'b1)
      state_q == ST_CLEAR: mem_we = 1'b1;
      state_q == ST_WB1: begin
        mem_we    = rise_do_q;
        mem_waddr = rise_idx_q;
        mem_wdata = rise_val_q;
      end
      state_q == ST_WB2: begin
        mem_we    = fall_found_q && !fall_blk_q;
        mem_waddr = fall_idx_q;
        mem_wdata = fall_val_q;
      end
      default: mem_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) lb_mem[mem_waddr] <= mem_wdata;
    rd_q <= lb_mem[mem_raddr];
  end

  // emit multiply, registered before the divide by 255
  always_ff @(posedge clk_i) begin
    if (state_q == ST_EMMUL) begin
      pr_r_q <= cur_col_q.red * rd_q;
      pr_g_q <= cur_col_q.green * rd_q;
      pr_b_q <= cur_col_q.blue * rd_q;
    end
  end

  assign out_red_o     = div255(pr_r_q);
  assign out_green_o   = div255(pr_g_q);
  assign out_blue_o    = div255(pr_b_q);
  assign pixel_index_o = 6'(o_q);
  assign frame_last_o  = (o_q == n_q - NW'(1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      led_count_q  <= RST_LED_COUNT;
      pos_count_q  <= RST_POS_COUNT;
      step_q       <= RST_STEP;
      max_b_q      <= RST_MAX_BR;
      min_b_q      <= RST_MIN_BR;
      rev_q        <= 1'b0;
      offset_q     <= '0;
      periodic_q   <= 1'b0;
      bar_on_q     <= 1'b0;
      tgt_col_q    <= RST_TARGET;
      cur_col_q    <= '0;
      fill_q       <= '0;
      n_q          <= '0;
      p_q          <= '0;
      offr_q       <= '0;
      dq_q         <= '0;
      k_q          <= '0;
      rr_q         <= '0;
      dcnt_q       <= '0;
      bnd_q        <= '0;
      col_chg_q    <= 1'b0;
      cnt_q        <= '0;
      p_idx_q      <= '0;
      p_vld_q      <= 1'b0;
      prev_mis_q   <= 1'b0;
      rise_found_q <= 1'b0;
      rise_do_q    <= 1'b0;
      fall_found_q <= 1'b0;
      fall_pend_q  <= 1'b0;
      fall_blk_q   <= 1'b0;
      rise_idx_q   <= '0;
      fall_idx_q   <= '0;
      rise_val_q   <= '0;
      fall_val_q   <= '0;
      o_q          <= '0;
      i_q          <= '0;
      clr_q        <= '0;
    end else begin
      state_q <= state_d;

      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_LED_COUNT: led_count_q <= cfg_data_i[6:0];
          CFG_POS_COUNT: pos_count_q <= cfg_data_i[POS_W-1:0];
          CFG_STEP:      step_q      <= cfg_data_i[7:0];
          CFG_MAX_BR:    max_b_q     <= cfg_data_i[7:0];
          CFG_MIN_BR:    min_b_q     <= cfg_data_i[7:0];
          CFG_REVERSE:   rev_q       <= cfg_data_i[0];
          CFG_OFFSET:    offset_q    <= cfg_data_i[6:0];
          CFG_PERIODIC:  periodic_q  <= cfg_data_i[0];
          default:       periodic_q  <= periodic_q;
        endcase
      end

      unique case (state_q)
        ST_CLEAR: clr_q <= clr_q + NW'(1);

        ST_IDLE: begin
          if (in_xfer) begin
            unique case (cmd_i)
              CMD_TICK: begin
                col_chg_q <= (cur_col_q != tgt_col_q);
                cur_col_q <= '{red:   move_toward(cur_col_q.red, tgt_col_q.red, step_q),
                               green: move_toward(cur_col_q.green, tgt_col_q.green, step_q),
                               blue:  move_toward(cur_col_q.blue, tgt_col_q.blue, step_q)};
                if (int'(led_count_q) > MAX_LEDS) begin
                  n_q  <= NW'(MAX_LEDS);
                  dq_q <= DW'(NW'(MAX_LEDS)) * DW'(fill_q);
                end else begin
                  n_q  <= NW'(led_count_q);
                  dq_q <= DW'(led_count_q) * DW'(fill_q);
                end
                p_q          <= (pos_count_q == '0) ? POS_W'(1) : pos_count_q;
                offr_q       <= offset_q;
                rr_q         <= '0;
                dcnt_q       <= CNTW'(DW);
                cnt_q        <= '0;
                p_vld_q      <= 1'b0;
                prev_mis_q   <= 1'b0;
                rise_found_q <= 1'b0;
                rise_do_q    <= 1'b0;
                fall_found_q <= 1'b0;
                fall_pend_q  <= 1'b0;
                fall_blk_q   <= 1'b0;
              end
              CMD_ENABLE:  bar_on_q  <= enable_on_i;
              CMD_TOGGLE:  bar_on_q  <= !bar_on_q;
              CMD_SET_COL: tgt_col_q <= '{red: new_red_i, green: new_green_i,
                                          blue: new_blue_i};
              CMD_SET_POS: begin
                if (new_position_i[13]) fill_q <= '0;
                else if (new_position_i[POS_W-1:0] > pos_count_q) fill_q <= pos_count_q;
                else fill_q <= new_position_i[POS_W-1:0];
              end
              default: bar_on_q <= bar_on_q;
            endcase
          end
        end

        ST_DIV1: begin
          if (dcnt_q != '0) begin
            rr_q   <= dv_ge ? dv_sub[POS_W-1:0] : dv_t[POS_W-1:0];
            dq_q   <= {dq_q[DW-2:0], dv_ge};
            dcnt_q <= dcnt_q - CNTW'(1);
          end else if (!off_big) begin
            // k is the quotient, now divide max_bright * rem by p
            k_q    <= dq_q;
            dq_q   <= DW'(max_b_q) * DW'(rr_q);
            rr_q   <= '0;
            dcnt_q <= CNTW'(DW);
          end
          if (off_big) offr_q <= 7'(OW'(offr_q) - OW'(n_q));
        end

        ST_DIV2: begin
          if (dcnt_q != '0) begin
            rr_q   <= dv_ge ? dv_sub[POS_W-1:0] : dv_t[POS_W-1:0];
            dq_q   <= {dq_q[DW-2:0], dv_ge};
            dcnt_q <= dcnt_q - CNTW'(1);
          end else begin
            bnd_q <= (dq_q[7:0] < min_b_q) ? min_b_q : dq_q[7:0];
          end
        end

        ST_SCAN: begin
          if (cnt_q != n_q) begin
            cnt_q   <= cnt_q + NW'(1);
            p_idx_q <= cnt_q;
            p_vld_q <= 1'b1;
          end else begin
            p_vld_q <= 1'b0;
          end
          if (p_vld_q) begin
            prev_mis_q <= (s_d != s_t);
            if (s_first) begin
              rise_found_q <= 1'b1;
              rise_do_q    <= s_allow;
              rise_idx_q   <= p_idx_q[AW-1:0];
              rise_val_q   <= s_rval;
            end
            // the fall is blocked if its upper neighbour is off target after the rise
            if (s_fall) begin
              fall_found_q <= 1'b1;
              fall_idx_q   <= p_idx_q[AW-1:0];
              fall_val_q   <= s_fval;
              fall_pend_q  <= 1'b1;
              fall_blk_q   <= 1'b0;
            end else begin
              fall_pend_q <= 1'b0;
              if (fall_pend_q) fall_blk_q <= (s_post != s_t);
            end
          end
        end

        ST_WB2: begin
          o_q <= '0;
          if (rev_q) i_q <= (offr_q == '0) ? n_q - NW'(1) : NW'(offr_q) - NW'(1);
          else       i_q <= (offr_q == '0) ? '0 : n_q - NW'(offr_q);
        end

        ST_EMOUT: begin
          if (out_xfer) begin
            o_q <= o_q + NW'(1);
            if (rev_q) i_q <= (i_q == '0) ? n_q - NW'(1) : i_q - NW'(1);
            else       i_q <= (i_q == n_q - NW'(1)) ? '0 : i_q + NW'(1);
          end
        end

        default: clr_q <= clr_q;
      endcase
    end
  end

  `include "led_bar_fill_ramp_macros.svh"

  `LBFR_ASSERT_IMP(a_no_input_during_frame, clk_i, rst_ni, out_valid_o, !in_ready_o, "input taken during frame")
  `LBFR_ASSERT_NXT(a_idle_after_last, clk_i, rst_ni, out_xfer && frame_last_o, in_ready_o, "not idle after last pixel")
  `LBFR_ASSERT_IMP(a_ramp_idx_differ, clk_i, rst_ni, state_q == ST_WB1 && rise_do_q && fall_found_q, rise_idx_q != fall_idx_q, "rise and fall hit same led")

endmodule
